[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the password policy checker.
// Needs nothing else; files that check their own logic include it by name.
// Each macro expands to a concurrent assertion, or to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is high
`define CHK_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled while reset is high
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CHK_SAME(lbl, clk, rst, ante, cons)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/ppc_pkg.sv]
// Types and constants for the password policy checker.
// Depends on nothing; used by the top level password_policy_checker.
`timescale 1ns / 1ps

package ppc_pkg;

   localparam int CHAR_W  = 8;
   localparam int CNT_W   = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int GROUP_W = 4;
   localparam int NUM_CLASSES = 4;
   localparam int MIN_CLASSES = 3;

   // Run length saturates at the store depth of the largest build
   localparam logic [CNT_W-1:0] RUN_SAT = 5'd16;

   // Register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LOWER    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_UPPER    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIGIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPECIAL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_LIMIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_ENABLES = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_GROUPS  = 3'd6;

   // Bit positions in rule_enables
   localparam int RULE_COMPLEXITY = 0;
   localparam int RULE_UNIQUE     = 1;
   localparam int RULE_MASK       = 2;

   typedef enum logic [1:0] {
      CLS_LOWER,
      CLS_UPPER,
      CLS_DIGIT,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } req_type;

   typedef struct packed {
      logic             accept;
      logic             too_long;
      logic [CNT_W-1:0] length_seen;
      logic [CNT_W-1:0] lower_count;
      logic [CNT_W-1:0] upper_count;
      logic [CNT_W-1:0] digit_count;
      logic [CNT_W-1:0] special_count;
   } rsp_type;

endpackage

[rtl/password_policy_checker.sv]
// Password policy checker: a candidate arrives one character per item on
// the req channel, a last_char flag closes it. The rsp channel carries one
// result item per candidate: accept, too_long, length and class counts.
// Rules are set on the csr channel (index 0..6, 64-bit data; index 7 is
// ignored). csr_ready is always high; write only while the block is idle.
//
// A final character passes from the input register into the result register,
// from which its result item is taken.
// Throughput: one item per cycle unless a final character waits for the result
// register. Each character is compared at once with every stored character by
// a row of 8-bit comparators; counts and run length update in the same cycle.
//
// Reset clears the rules to zero (all checks off) and empties the candidate
// state. When the receiver holds rsp_ready low, characters that produce no
// result keep flowing; a final character waits in the input register until
// the result register frees, and req_ready drops behind it.
// Candidates longer than MAX_CHARS keep only the first MAX_CHARS characters
// and are rejected with too_long set.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module password_policy_checker #(
   parameter int MAX_CHARS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ppc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ppc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ppc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ppc_pkg::*;

   localparam int PW = $clog2(MAX_CHARS + 1);
   localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam logic [PW-1:0] POS_MAX = PW'(MAX_CHARS);

   // Rule registers
   logic [CNT_W-1:0]      min_lower_ff, min_upper_ff, min_digit_ff, min_special_ff;
   logic [CNT_W-1:0]      run_limit_ff;
   logic [2:0]            rule_en_ff;
   logic [CSR_DATA_W-1:0] mask_ff;

   // Input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff;

   // Candidate state
   logic [CHAR_W-1:0] store_ff [MAX_CHARS];
   logic [CHAR_W-1:0] prev_ff;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]  cnt_ff [NUM_CLASSES];
   logic [CNT_W-1:0]  cnt_in [NUM_CLASSES];
   logic [CNT_W-1:0]  run_ff, run_in;
   logic              fail_ff, fail_in;
   logic              ovf_ff, ovf_in;

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Working signals
   logic              out_free, s1_fire, req_fire, take, clear;
   logic [CHAR_W-1:0] ch;
   logic [AW-1:0]     idx;
   logic [GROUP_W-1:0] grp_p;
   logic              rule_hit, run_match, run_hit;
   logic [CNT_W-1:0]  run_upd;
   logic [PW-1:0]     pos_upd;
   logic [CNT_W-1:0]  cnt_upd [NUM_CLASSES];
   logic              fail_upd, ovf_upd;
   char_class_type    cls;
   logic [2:0]        present;
   logic              mins_ok, ok;

   // Handshake: the input register moves on unless a result has nowhere to go
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_ff.last_char || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign ch    = s1_ff.char_code;
   assign take  = (pos_ff < POS_MAX);
   assign idx   = AW'(pos_ff);
   assign clear = s1_fire && s1_ff.last_char;

   // Classify the character
   always_comb begin
      if (ch >= 8'h61 && ch <= 8'h7a) begin
         cls = CLS_LOWER;
      end else if (ch >= 8'h41 && ch <= 8'h5a) begin
         cls = CLS_UPPER;
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         cls = CLS_DIGIT;
      end else begin
         cls = CLS_OTHER;
      end
   end

   // Select the mask group of the incoming position
   always_comb begin
      grp_p = '0;
      for (int m = 0; m < MAX_CHARS; m++) begin
         if (idx == AW'(m)) begin
            grp_p = mask_ff[GROUP_W*m +: GROUP_W];
         end
      end
   end

   // Compare against every stored character of this candidate
   always_comb begin
      logic same, same_grp, older;
      rule_hit = 1'b0;
      for (int m = 0; m < MAX_CHARS; m++) begin
         same     = (store_ff[m] == ch);
         same_grp = (mask_ff[GROUP_W*m +: GROUP_W] == grp_p);
         older    = (PW'(m) < pos_ff);
         if (older && rule_en_ff[RULE_UNIQUE] && same) begin
            rule_hit = 1'b1;
         end
         if (older && rule_en_ff[RULE_MASK] && (same_grp != same)) begin
            rule_hit = 1'b1;
         end
      end
   end

   // Run of equal characters
   assign run_match = (pos_ff != '0) && (prev_ff == ch);
   assign run_upd   = run_match ? ((run_ff < RUN_SAT) ? run_ff + 5'd1 : run_ff) : 5'd1;
   assign run_hit   = (run_limit_ff != '0) && (run_upd >= run_limit_ff);

   // State after this character, before any clear
   always_comb begin
      pos_upd  = take ? pos_ff + PW'(1) : pos_ff;
      fail_upd = fail_ff || (take && (rule_hit || run_hit));
      ovf_upd  = ovf_ff || !take;
      for (int k = 0; k < NUM_CLASSES; k++) begin
         cnt_upd[k] = cnt_ff[k] + CNT_W'(take && (cls == char_class_type'(k)));
      end
   end

   // Final checks on the updated counts
   always_comb begin
      present = '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
         present = present + 3'(cnt_upd[k] != '0);
      end
      mins_ok = (cnt_upd[CLS_LOWER] >= min_lower_ff) &&
                (cnt_upd[CLS_UPPER] >= min_upper_ff) &&
                (cnt_upd[CLS_DIGIT] >= min_digit_ff) &&
                (cnt_upd[CLS_OTHER] >= min_special_ff);
      ok = !fail_upd && !ovf_upd && mins_ok &&
           (!rule_en_ff[RULE_COMPLEXITY] || (present >= 3'(MIN_CLASSES)));
      rsp_in.accept        = ok;
      rsp_in.too_long      = ovf_upd;
      rsp_in.length_seen   = CNT_W'(pos_upd);
      rsp_in.lower_count   = cnt_upd[CLS_LOWER];
      rsp_in.upper_count   = cnt_upd[CLS_UPPER];
      rsp_in.digit_count   = cnt_upd[CLS_DIGIT];
      rsp_in.special_count = cnt_upd[CLS_OTHER];
   end

   // Next candidate state: hold, advance, or clear after a result
   always_comb begin
      pos_in  = pos_ff;
      run_in  = run_ff;
      fail_in = fail_ff;
      ovf_in  = ovf_ff;
      for (int k = 0; k < NUM_CLASSES; k++) begin
         cnt_in[k] = cnt_ff[k];
      end
      if (clear) begin
         pos_in  = '0;
         run_in  = '0;
         fail_in = 1'b0;
         ovf_in  = 1'b0;
         for (int k = 0; k < NUM_CLASSES; k++) begin
            cnt_in[k] = '0;
         end
      end else if (s1_fire) begin
         pos_in  = pos_upd;
         run_in  = take ? run_upd : run_ff;
         fail_in = fail_upd;
         ovf_in  = ovf_upd;
         for (int k = 0; k < NUM_CLASSES; k++) begin
            cnt_in[k] = cnt_upd[k];
         end
      end
   end

   // Valid flags of the two registers
   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = clear ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Control state and rule registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pos_ff         <= '0;
         run_ff         <= '0;
         fail_ff        <= 1'b0;
         ovf_ff         <= 1'b0;
         for (int k = 0; k < NUM_CLASSES; k++) begin
            cnt_ff[k] <= '0;
         end
         min_lower_ff   <= '0;
         min_upper_ff   <= '0;
         min_digit_ff   <= '0;
         min_special_ff <= '0;
         run_limit_ff   <= '0;
         rule_en_ff     <= '0;
         mask_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         run_ff       <= run_in;
         fail_ff      <= fail_in;
         ovf_ff       <= ovf_in;
         for (int k = 0; k < NUM_CLASSES; k++) begin
            cnt_ff[k] <= cnt_in[k];
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MIN_LOWER:    min_lower_ff   <= csr_data[CNT_W-1:0];
               CSR_MIN_UPPER:    min_upper_ff   <= csr_data[CNT_W-1:0];
               CSR_MIN_DIGIT:    min_digit_ff   <= csr_data[CNT_W-1:0];
               CSR_MIN_SPECIAL:  min_special_ff <= csr_data[CNT_W-1:0];
               CSR_RUN_LIMIT:    run_limit_ff   <= csr_data[CNT_W-1:0];
               CSR_RULE_ENABLES: rule_en_ff     <= csr_data[2:0];
               CSR_MASK_GROUPS:  mask_ff        <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Payload registers: input item, result item, character store
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= req_data;
      end
      if (clear) begin
         rsp_ff <= rsp_in;
      end
      if (s1_fire && take) begin
         store_ff[idx] <= ch;
         prev_ff       <= ch;
      end
   end

   // Checks on the candidate bookkeeping
   logic [CNT_W+1:0] cnt_sum;
   assign cnt_sum = (CNT_W+2)'(cnt_ff[0]) + (CNT_W+2)'(cnt_ff[1]) +
                    (CNT_W+2)'(cnt_ff[2]) + (CNT_W+2)'(cnt_ff[3]);

   `CHK_NEXT(a_final_gives_rsp, clock, reset, clear, rsp_valid_ff)
   `CHK_NEXT(a_final_clears, clock, reset, clear, (pos_ff == '0) && (run_ff == '0) && !ovf_ff)
   `CHK_SAME(a_counts_match_pos, clock, reset, 1'b1, cnt_sum == (CNT_W+2)'(pos_ff))
   `CHK_SAME(a_ovf_at_full, clock, reset, ovf_ff, pos_ff == POS_MAX)
   `CHK_SAME(a_long_rejects, clock, reset, rsp_valid_ff && rsp_ff.too_long, !rsp_ff.accept)

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for password_policy_checker: streams candidate passwords
// over req, predicts each result item in its own policy model and checks rsp items.
// Depends on ppc_pkg and the password_policy_checker RTL.
`timescale 1ns / 1ps

module testbench;
   import ppc_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 12;
   localparam int MAX_KEPT       = 16;
   localparam int SETTLE_CYCLES  = 6;
   localparam int TAIL_CYCLES    = 10;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 65;
   localparam int HOLD_PHASE     = 1;
   localparam int PAUSE_PHASE    = 4;
   localparam int MAX_REPORTS    = 10;

   // Index with no register behind it; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef enum {IDLE_SEND_LIGHT, IDLE_RECV_LIGHT, IDLE_NONE} idle_mode_type;
   typedef enum {ROW_CHAR, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] value;
      req_type               item;
      bit                    typed;
      rsp_type               want;
   } dir_row_type;

   typedef logic [CHAR_W-1:0] char_q_type [$];

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Policy registers as the predictor sees them
   logic [CNT_W-1:0]      rule_min [NUM_CLASSES];
   logic [CNT_W-1:0]      rule_run;
   logic [2:0]            rule_bits;
   logic [CSR_DATA_W-1:0] rule_groups;

   // Candidate state of the predictor
   logic [CHAR_W-1:0]     kept [MAX_KEPT];
   logic [CNT_W-1:0]      kept_n;
   logic [CNT_W-1:0]      class_n [NUM_CLASSES];
   logic [CNT_W-1:0]      run_n;
   logic                  policy_fail;
   logic                  overflow;

   rsp_type               pending_results [$];
   int                    error_count = 0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    quiet_cycles = 0;
   int                    hold_left = 0;
   logic                  hold_req = 1'b0;
   logic                  hold_taken = 1'b0;
   dir_row_type           dir_rows [$];

   password_policy_checker #(.MAX_CHARS(MAX_KEPT)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic char_class_type class_of(input logic [CHAR_W-1:0] c);
      if (c >= 8'h61 && c <= 8'h7A) return CLS_LOWER;   // a..z
      if (c >= 8'h41 && c <= 8'h5A) return CLS_UPPER;   // A..Z
      if (c >= 8'h30 && c <= 8'h39) return CLS_DIGIT;   // 0..9
      return CLS_OTHER;
   endfunction

   function automatic void clear_candidate();
      kept_n = '0;
      for (int k = 0; k < NUM_CLASSES; k++) class_n[k] = '0;
      run_n = '0;
      policy_fail = 1'b0;
      overflow = 1'b0;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_MIN_LOWER:    rule_min[CLS_LOWER] = value[CNT_W-1:0];
         CSR_MIN_UPPER:    rule_min[CLS_UPPER] = value[CNT_W-1:0];
         CSR_MIN_DIGIT:    rule_min[CLS_DIGIT] = value[CNT_W-1:0];
         CSR_MIN_SPECIAL:  rule_min[CLS_OTHER] = value[CNT_W-1:0];
         CSR_RUN_LIMIT:    rule_run = value[CNT_W-1:0];
         CSR_RULE_ENABLES: rule_bits = value[2:0];
         CSR_MASK_GROUPS:  rule_groups = value;
         default: ;
      endcase
   endfunction

   // Take one character into the candidate; return 1 with the verdict on a final one
   function automatic bit judge_char(input req_type item, output rsp_type verdict);
      logic [CHAR_W-1:0] c;
      logic [CNT_W-1:0]  p;
      logic              same;
      logic              same_group;
      int                classes;
      logic              ok;
      c = item.char_code;
      verdict = '0;
      if (kept_n >= MAX_KEPT) begin
         // Past the store: flag only, nothing kept or checked
         overflow = 1'b1;
      end else begin
         p = kept_n;
         for (int m = 0; m < p; m++) begin
            same = (kept[m] == c);
            if (rule_bits[RULE_UNIQUE] && same) policy_fail = 1'b1;
            if (rule_bits[RULE_MASK]) begin
               same_group = (rule_groups[m*GROUP_W +: GROUP_W] ==
                             rule_groups[p*GROUP_W +: GROUP_W]);
               if (same_group != same) policy_fail = 1'b1;
            end
         end
         if (p > 0 && kept[p-1] == c) begin
            if (run_n < RUN_SAT) run_n++;
         end else begin
            run_n = CNT_W'(1);
         end
         if (rule_run != 0 && run_n >= rule_run) policy_fail = 1'b1;
         class_n[class_of(c)]++;
         kept[p] = c;
         kept_n = p + CNT_W'(1);
      end
      if (!item.last_char) return 1'b0;

      ok = !policy_fail && !overflow;
      classes = 0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
         if (class_n[k] < rule_min[k]) ok = 1'b0;
         if (class_n[k] != 0) classes++;
      end
      if (rule_bits[RULE_COMPLEXITY] && classes < MIN_CLASSES) ok = 1'b0;

      verdict.accept        = ok;
      verdict.too_long      = overflow;
      verdict.length_seen   = kept_n;
      verdict.lower_count   = class_n[CLS_LOWER];
      verdict.upper_count   = class_n[CLS_UPPER];
      verdict.digit_count   = class_n[CLS_DIGIT];
      verdict.special_count = class_n[CLS_OTHER];
      clear_candidate();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_SEND_LIGHT: begin send_idle_pct = 12; recv_idle_pct = 60; end
         IDLE_RECV_LIGHT: begin send_idle_pct = 60; recv_idle_pct = 12; end
         default:         begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
   endtask

   // Offer one item, hold it until accepted, then queue its expected result if it is final
   task automatic send_item(input req_type item, input bit typed, input rsp_type want);
      rsp_type got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (judge_char(item, got)) pending_results.push_back(typed ? want : got);
   endtask

   // Stop sending and wait until the block has drained
   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_reg(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Place a field value on the bus, sometimes with junk above the field
   function automatic logic [CSR_DATA_W-1:0] field_word(input logic [CNT_W-1:0] v,
                                                        input int width);
      logic [CSR_DATA_W-1:0] junk;
      junk = ($urandom_range(1) != 0) ? {$urandom(), $urandom()} : '0;
      return (junk << width) | CSR_DATA_W'(v);
   endfunction

   function automatic logic [CHAR_W-1:0] rand_char();
      case ($urandom_range(4))
         0:       return CHAR_W'(8'h61 + $urandom_range(25));
         1:       return CHAR_W'(8'h41 + $urandom_range(25));
         2:       return CHAR_W'(8'h30 + $urandom_range(9));
         default: return CHAR_W'($urandom_range(255, 1));
      endcase
   endfunction

   // Pick the policy for one phase: zeros, then maxima, then random mixes
   task automatic program_phase(input int phase);
      logic [CNT_W-1:0]      mins [NUM_CLASSES];
      logic [CNT_W-1:0]      run_v;
      logic [2:0]            bits_v;
      logic [CSR_DATA_W-1:0] groups_v;
      if (phase == 0) begin
         for (int k = 0; k < NUM_CLASSES; k++) mins[k] = '0;
         run_v = '0;
         bits_v = '0;
         groups_v = '0;
      end else if (phase == 1) begin
         for (int k = 0; k < NUM_CLASSES; k++) mins[k] = CNT_W'(MAX_KEPT);
         run_v = CNT_W'(MAX_KEPT);
         bits_v = 3'b111;
         groups_v = '1;
      end else begin
         for (int k = 0; k < NUM_CLASSES; k++) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: mins[k] = '0;
               9:                mins[k] = CNT_W'($urandom_range(MAX_KEPT));
               default:          mins[k] = CNT_W'($urandom_range(3, 1));
            endcase
         end
         if ($urandom_range(1) == 0) run_v = '0;
         else if ($urandom_range(9) == 0) run_v = CNT_W'($urandom_range(MAX_KEPT, 9));
         else run_v = CNT_W'($urandom_range(8, 1));
         bits_v = 3'($urandom_range(7));
         case ($urandom_range(2))
            0: groups_v = {$urandom(), $urandom()};
            1: for (int g = 0; g < MAX_KEPT; g++)
                  groups_v[g*GROUP_W +: GROUP_W] = GROUP_W'($urandom_range(3));
            default: for (int g = 0; g < MAX_KEPT; g++)
                  groups_v[g*GROUP_W +: GROUP_W] = GROUP_W'(g);
         endcase
      end
      quiesce();
      write_reg(CSR_MIN_LOWER,    field_word(mins[CLS_LOWER], CNT_W));
      write_reg(CSR_MIN_UPPER,    field_word(mins[CLS_UPPER], CNT_W));
      write_reg(CSR_MIN_DIGIT,    field_word(mins[CLS_DIGIT], CNT_W));
      write_reg(CSR_MIN_SPECIAL,  field_word(mins[CLS_OTHER], CNT_W));
      write_reg(CSR_RUN_LIMIT,    field_word(run_v, CNT_W));
      write_reg(CSR_RULE_ENABLES, field_word(CNT_W'(bits_v), 3));
      write_reg(CSR_MASK_GROUPS,  groups_v);
      if (phase == 2) write_reg(CSR_UNUSED, {$urandom(), $urandom()});
   endtask

   // Build one candidate: mostly mask-conforming, unique or run-heavy strings
   task automatic make_candidate(output char_q_type chars);
      logic [CHAR_W-1:0] group_char [MAX_KEPT];
      bit                used [256];
      logic [CHAR_W-1:0] c;
      int                len;
      int                style;
      chars = {};
      used = '{default: 1'b0};
      len = ($urandom_range(9) < 7) ? $urandom_range(6, 1) : $urandom_range(MAX_KEPT, 7);
      if ($urandom_range(19) == 0) len = $urandom_range(MAX_KEPT + 4, MAX_KEPT + 1);
      style = $urandom_range(99);
      if (style < 40) begin
         // One distinct character per mask group, with an occasional corruption
         for (int g = 0; g < MAX_KEPT; g++) begin
            do c = rand_char(); while (used[c]);
            used[c] = 1'b1;
            group_char[g] = c;
         end
         for (int i = 0; i < len; i++)
            chars.push_back(group_char[rule_groups[(i % MAX_KEPT)*GROUP_W +: GROUP_W]]);
         if ($urandom_range(4) == 0) chars[$urandom_range(len - 1)] = rand_char();
      end else if (style < 60) begin
         for (int i = 0; i < len; i++) begin
            do c = rand_char(); while (used[c]);
            used[c] = 1'b1;
            chars.push_back(c);
         end
      end else if (style < 80) begin
         c = rand_char();
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(3) == 0) c = rand_char();
            chars.push_back(c);
         end
      end else begin
         for (int i = 0; i < len; i++) chars.push_back(rand_char());
      end
   endtask

   // ---------------------------------------------------------------- directed table

   function automatic void add_char(input logic [CHAR_W-1:0] c, input logic last);
      dir_row_type row;
      row = '{kind: ROW_CHAR, index: '0, value: '0, item: '{c, last}, typed: 1'b0,
              want: '0};
      dir_rows.push_back(row);
   endfunction

   function automatic void add_final(input logic [CHAR_W-1:0] c, input rsp_type want);
      dir_row_type row;
      row = '{kind: ROW_CHAR, index: '0, value: '0, item: '{c, 1'b1}, typed: 1'b1,
              want: want};
      dir_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] index,
                                   input logic [CSR_DATA_W-1:0] value);
      dir_row_type row;
      row = '{kind: ROW_CSR, index: index, value: value, item: '0, typed: 1'b0,
              want: '0};
      dir_rows.push_back(row);
   endfunction

   // ---------------------------------------------------------------- receiver

   // Randomly stall rsp; on request hold off for one long stretch
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if (!hold_req) hold_taken <= 1'b0;
   end

   function automatic string rsp_text(input rsp_type r);
      return $sformatf("accept=%0d too_long=%0d len=%0d lower=%0d upper=%0d digit=%0d other=%0d",
                       r.accept, r.too_long, r.length_seen, r.lower_count,
                       r.upper_count, r.digit_count, r.special_count);
   endfunction

   // Compare each accepted result item with the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result item: %s", rsp_text(rsp_data));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.accept !== want.accept || rsp_data.too_long !== want.too_long ||
                rsp_data.length_seen !== want.length_seen ||
                rsp_data.lower_count !== want.lower_count ||
                rsp_data.upper_count !== want.upper_count ||
                rsp_data.digit_count !== want.digit_count ||
                rsp_data.special_count !== want.special_count) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("mismatch: expected %s, got %s", rsp_text(want), rsp_text(rsp_data));
            end
         end
      end
   end

   // End the run when no channel has moved an item for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main flow

   initial begin : main_flow
      char_q_type chars;
      req_type    item;
      int         sent;
      bit         paused;

      for (int k = 0; k < NUM_CLASSES; k++) rule_min[k] = '0;
      rule_run = '0;
      rule_bits = '0;
      rule_groups = '0;
      clear_candidate();
      paused = 1'b0;

      // Reset policy: single characters of each class and the code extremes
      add_final(8'h61, '{1'b1, 1'b0, 5'd1, 5'd1, 5'd0, 5'd0, 5'd0});
      add_final(8'h5A, '{1'b1, 1'b0, 5'd1, 5'd0, 5'd1, 5'd0, 5'd0});
      add_final(8'h30, '{1'b1, 1'b0, 5'd1, 5'd0, 5'd0, 5'd1, 5'd0});
      add_final(8'h00, '{1'b1, 1'b0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd1});
      add_final(8'hFF, '{1'b1, 1'b0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd1});
      // Too long: the character past the store is dropped and flags the candidate
      for (int i = 0; i < MAX_KEPT; i++) add_char(8'h78, 1'b0);
      add_final(8'h51, '{1'b0, 1'b1, 5'd16, 5'd16, 5'd0, 5'd0, 5'd0});
      // Run limit of one rejects any kept character
      add_csr(CSR_RUN_LIMIT, 64'd1);
      add_final(8'h62, '{1'b0, 1'b0, 5'd1, 5'd1, 5'd0, 5'd0, 5'd0});
      // A minimum no short candidate can reach
      add_csr(CSR_RUN_LIMIT, 64'd0);
      add_csr(CSR_MIN_LOWER, 64'd16);
      add_final(8'h63, '{1'b0, 1'b0, 5'd1, 5'd1, 5'd0, 5'd0, 5'd0});
      // Every rule on with one group per position
      add_csr(CSR_MIN_LOWER, 64'd0);
      add_csr(CSR_RULE_ENABLES, 64'd7);
      add_csr(CSR_MASK_GROUPS, 64'hFEDC_BA98_7654_3210);
      add_char(8'h61, 1'b0);
      add_char(8'h42, 1'b0);
      add_char(8'h33, 1'b1);

      set_idle(IDLE_SEND_LIGHT);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            quiesce();
            write_reg(dir_rows[i].index, dir_rows[i].value);
         end else begin
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // Random candidates, one policy per phase
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase < 3) set_idle(IDLE_SEND_LIGHT);
         else if (phase < 6) set_idle(IDLE_RECV_LIGHT);
         else set_idle(IDLE_NONE);
         program_phase(phase);
         if (phase == HOLD_PHASE) hold_req <= 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            make_candidate(chars);
            foreach (chars[i]) begin
               item.char_code = chars[i];
               item.last_char = (i == chars.size() - 1);
               send_item(item, 1'b0, '0);
            end
            sent += chars.size();
            // Pause the sender once until every result has come back
            if (phase == PAUSE_PHASE && !paused && sent >= PHASE_ITEMS / 2) begin
               quiesce();
               paused = 1'b1;
            end
         end
         hold_req <= 1'b0;
      end

      // Drain and report
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      error_count += pending_results.size();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/ppc_pkg.sv
rtl/password_policy_checker.sv
tb/sv/testbench.sv
